// ===== src/dks_pkg.sv =====
package dks_pkg;

  localparam int KEY_W   = 64;
  localparam int CD_W    = 56;
  localparam int HALF_W  = 28;
  localparam int SUB_W   = 48;
  localparam int IDX_W   = 4;
  localparam int ROUNDS  = 16;
  localparam int OUT_W   = 56;  // round_key + round_index, padded to bytes

  localparam logic [IDX_W-1:0] LAST_ROUND = IDX_W'(ROUNDS - 1);

  // bit r set where round r rotates by two, clear where it rotates by one
  localparam logic [ROUNDS-1:0] SHIFT_TWO = 16'h7EFC;

  // standard DES permuted choice tables, positions counted from the msb as 1
  localparam int PC1_TAB [CD_W] = '{
    57, 49, 41, 33, 25, 17,  9,  1, 58, 50, 42, 34, 26, 18,
    10,  2, 59, 51, 43, 35, 27, 19, 11,  3, 60, 52, 44, 36,
    63, 55, 47, 39, 31, 23, 15,  7, 62, 54, 46, 38, 30, 22,
    14,  6, 61, 53, 45, 37, 29, 21, 13,  5, 28, 20, 12,  4
  };

  localparam int PC2_TAB [SUB_W] = '{
    14, 17, 11, 24,  1,  5,  3, 28, 15,  6, 21, 10,
    23, 19, 12,  4, 26,  8, 16,  7, 27, 20, 13,  2,
    41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
    44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
  };

  // rotated halves of one round on their way to pc-2
  typedef struct packed {
    logic [CD_W-1:0]  cd;
    logic [IDX_W-1:0] idx;
    logic             last;
  } rnd_t;

  function automatic logic [CD_W-1:0] pc1(input logic [KEY_W-1:0] k);
    logic [CD_W-1:0] r;
    r = '0;
    for (int i = 0; i < CD_W; i++) begin
      r[CD_W-1-i] = k[KEY_W-PC1_TAB[i]];
    end
    return r;
  endfunction

  function automatic logic [SUB_W-1:0] pc2(input logic [CD_W-1:0] cd);
    logic [SUB_W-1:0] r;
    r = '0;
    for (int i = 0; i < SUB_W; i++) begin
      r[SUB_W-1-i] = cd[CD_W-PC2_TAB[i]];
    end
    return r;
  endfunction

  function automatic logic [HALF_W-1:0] rotl(input logic [HALF_W-1:0] v, input logic two);
    logic [HALF_W-1:0] r;
    if (two) begin
      r = {v[HALF_W-3:0], v[HALF_W-1:HALF_W-2]};
    end else begin
      r = {v[HALF_W-2:0], v[HALF_W-1]};
    end
    return r;
  endfunction

endpackage

// ===== src/dks_pc1.sv =====
module dks_pc1 (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [dks_pkg::KEY_W-1:0] key,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [dks_pkg::CD_W-1:0]  cd
);
  import dks_pkg::*;

  logic valid;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cd <= pc1(key);
    end
  end

endmodule

// ===== src/dks_rounds.sv =====
module dks_rounds (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [dks_pkg::CD_W-1:0] cd_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output dks_pkg::rnd_t           out_rnd
);
  import dks_pkg::*;

  logic              busy;
  logic [HALF_W-1:0] c;
  logic [HALF_W-1:0] d;
  logic [IDX_W-1:0]  cnt;
  logic              valid;
  logic              adv;
  logic              done;
  logic [HALF_W-1:0] c_next;
  logic [HALF_W-1:0] d_next;

  assign adv      = busy && (!valid || out_ready);
  assign done     = adv && (cnt == LAST_ROUND);
  // next key loads in the same cycle the final round leaves
  assign in_ready = !busy || done;
  assign c_next   = rotl(c, SHIFT_TWO[cnt]);
  assign d_next   = rotl(d, SHIFT_TWO[cnt]);
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      cnt   <= '0;
      valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (done) begin
        busy <= 1'b0;
      end else if (adv) begin
        cnt <= cnt + 1'b1;
      end
      if (adv) begin
        valid <= 1'b1;
      end else if (out_ready) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      c <= cd_in[CD_W-1:HALF_W];
      d <= cd_in[HALF_W-1:0];
    end else if (adv) begin
      c <= c_next;
      d <= d_next;
    end
    if (adv) begin
      out_rnd.cd   <= {c_next, d_next};
      out_rnd.idx  <= cnt;
      out_rnd.last <= (cnt == LAST_ROUND);
    end
  end

endmodule

// ===== src/dks_pc2.sv =====
module dks_pc2 (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  dks_pkg::rnd_t             in_rnd,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [dks_pkg::SUB_W-1:0] round_key,
  output logic [dks_pkg::IDX_W-1:0] round_index,
  output logic                      last
);
  import dks_pkg::*;

  logic valid;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      round_key   <= pc2(in_rnd.cd);
      round_index <= in_rnd.idx;
      last        <= in_rnd.last;
    end
  end

endmodule

// ===== src/des_key_schedule.sv =====
// channel | dir | tdata bits (low up)                        | tuser | tlast
// s_*     | in  | key[63:0]                                  | none  | none
// m_*     | out | round_key[47:0], round_index[51:48], 0 pad | none  | last round
//
// each key gives sixteen subkeys, one item per cycle unless m_tready stalls the output;
// the round sequencer (one rotation per cycle) sets that rate and takes the next key
// as the last round leaves; key to subkey passes pc-1, c/d load, rotate, pc-2
// rst is synchronous and clears only the valid bits and the round sequencer
// m_tready low backs the stages up and holds them; nothing is dropped or repeated
module des_key_schedule (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // key[63:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // round_key[47:0], round_index[51:48], zeros[55:52]
  output logic        m_tlast
);
  import dks_pkg::*;

  // pc-1 stage to round sequencer
  logic             p1_valid;
  logic             p1_ready;
  logic [CD_W-1:0]  p1_cd;

  // round sequencer to pc-2 stage
  logic             rd_valid;
  logic             rd_ready;
  rnd_t             rd_rnd;

  logic [SUB_W-1:0] round_key;
  logic [IDX_W-1:0] round_index;

  dks_pc1 u_pc1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .key       (s_tdata),
    .out_valid (p1_valid),
    .out_ready (p1_ready),
    .cd        (p1_cd)
  );

  // holds C and D and walks the sixteen rotations
  dks_rounds u_rounds (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p1_valid),
    .in_ready  (p1_ready),
    .cd_in     (p1_cd),
    .out_valid (rd_valid),
    .out_ready (rd_ready),
    .out_rnd   (rd_rnd)
  );

  // pc-2 selection into the output register
  dks_pc2 u_pc2 (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (rd_valid),
    .in_ready    (rd_ready),
    .in_rnd      (rd_rnd),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .round_key   (round_key),
    .round_index (round_index),
    .last        (m_tlast)
  );

  // pad bits stay zero
  assign m_tdata = {(OUT_W - SUB_W - IDX_W)'(0), round_index, round_key};

endmodule

// ===== src/dks_checker.sv =====
module dks_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tlast
);
  import dks_pkg::*;

  logic [IDX_W-1:0] exp_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= '0;
    end else if (m_tvalid && m_tready) begin
      exp_idx <= m_tlast ? '0 : exp_idx + 1'b1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_last_round: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[51:48] == LAST_ROUND)))
    else $error("tlast does not match round 15");

  a_round_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[51:48] == exp_idx))
    else $error("subkey out of round order");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[55:52] == 4'h0))
    else $error("pad bits not zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled item changed");

endmodule

bind des_key_schedule dks_checker u_dks_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== dv/dks_subkey_checker.sv =====
`timescale 1ns / 100ps

// watches both channels of the key schedule, expands every accepted key into
// its sixteen subkeys and compares each subkey item against the oldest one due
module dks_subkey_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [dks_pkg::KEY_W-1:0] s_tdata,    // key[63:0]
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [dks_pkg::OUT_W-1:0] m_tdata,    // round_key[47:0], round_index[51:48], zeros[55:52]
  input  logic                      m_tlast,
  output int                        mismatches,
  output int                        outstanding
);
  import dks_pkg::*;

  typedef struct packed {
    logic [SUB_W-1:0] round_key;
    logic [IDX_W-1:0] round_index;
    logic             last_round;
  } subkey_t;

  // pc-1: key bit positions (1 = msb) feeding c:d, msb first
  localparam int KEY_SELECT [CD_W] = '{
    57, 49, 41, 33, 25, 17,  9,  1, 58, 50, 42, 34, 26, 18,
    10,  2, 59, 51, 43, 35, 27, 19, 11,  3, 60, 52, 44, 36,
    63, 55, 47, 39, 31, 23, 15,  7, 62, 54, 46, 38, 30, 22,
    14,  6, 61, 53, 45, 37, 29, 21, 13,  5, 28, 20, 12,  4
  };

  // pc-2: c:d bit positions (1 = msb) feeding the subkey, msb first
  localparam int CD_SELECT [SUB_W] = '{
    14, 17, 11, 24,  1,  5,  3, 28, 15,  6, 21, 10,
    23, 19, 12,  4, 26,  8, 16,  7, 27, 20, 13,  2,
    41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
    44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
  };

  localparam int ROT_AMOUNT [ROUNDS] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

  subkey_t pending_subkeys [$];

  task automatic expand_key(input logic [KEY_W-1:0] key);
    logic [CD_W-1:0]   cd;
    logic [HALF_W-1:0] c;
    logic [HALF_W-1:0] d;
    logic [CD_W-1:0]   joined;
    subkey_t           sk;
    for (int i = 0; i < CD_W; i++) begin
      cd[CD_W-1-i] = key[KEY_W-KEY_SELECT[i]];
    end
    c = cd[CD_W-1:HALF_W];
    d = cd[HALF_W-1:0];
    for (int r = 0; r < ROUNDS; r++) begin
      for (int s = 0; s < ROT_AMOUNT[r]; s++) begin
        c = {c[HALF_W-2:0], c[HALF_W-1]};
        d = {d[HALF_W-2:0], d[HALF_W-1]};
      end
      joined = {c, d};
      for (int i = 0; i < SUB_W; i++) begin
        sk.round_key[SUB_W-1-i] = joined[CD_W-CD_SELECT[i]];
      end
      sk.round_index = IDX_W'(r);
      sk.last_round  = (r == ROUNDS - 1);
      pending_subkeys.push_back(sk);
    end
  endtask

  always @(posedge clk) begin
    subkey_t want;
    if (rst) begin
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expand_key(s_tdata);
      end
      if (m_tvalid && m_tready) begin
        if (pending_subkeys.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: subkey item with none due: tdata %h tlast %b",
                     $realtime, m_tdata, m_tlast);
          end
          mismatches++;
        end else begin
          want = pending_subkeys.pop_front();
          if (m_tdata[SUB_W-1:0] !== want.round_key ||
              m_tdata[SUB_W+IDX_W-1:SUB_W] !== want.round_index ||
              m_tlast !== want.last_round ||
              m_tdata[OUT_W-1:SUB_W+IDX_W] !== '0) begin
            if (mismatches < 10) begin
              $display("%0t: subkey mismatch: key exp %h got %h, round exp %0d got %0d, %s",
                       $realtime, want.round_key, m_tdata[SUB_W-1:0], want.round_index,
                       m_tdata[SUB_W+IDX_W-1:SUB_W],
                       $sformatf("last exp %b got %b, pad got %h", want.last_round,
                                 m_tlast, m_tdata[OUT_W-1:SUB_W+IDX_W]));
            end
            mismatches++;
          end
        end
      end
      outstanding = pending_subkeys.size();
    end
  end

endmodule

// ===== dv/des_key_schedule_tb.sv =====
`timescale 1ns / 100ps

// stimulus and verdict for the key schedule; checking lives in dks_subkey_checker
module des_key_schedule_tb;

  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int STALL_LIMIT = 3000;  // cycles with no item moving before giving up
  localparam int DRAIN_WAIT  = 20;    // extra wait after the last subkey

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        m_tlast;

  int   mismatches;
  int   outstanding;
  int   quiet_cycles;
  int   tx_idle_pct;
  int   rx_idle_pct;
  logic hold_toggle;

  des_key_schedule dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  dks_subkey_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog: run ends if no item moves on either channel for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off each time hold_toggle flips
  initial begin
    int   hold_left;
    logic seen_toggle;
    m_tready    = 1'b0;
    hold_left   = 0;
    seen_toggle = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        m_tready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // mostly dense random keys, some single-bit and single-hole keys
  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    case ($urandom_range(9))
      0:       k = 64'd1 << $urandom_range(63);
      1:       k = ~(64'd1 << $urandom_range(63));
      default: k = {$urandom, $urandom};
    endcase
    return k;
  endfunction

  // offer one key, with random gaps before it, and hold it until taken
  task automatic send_key(input logic [63:0] key);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = key;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // let every due subkey come out before moving on
  task automatic drain();
    s_tvalid = 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
  endtask

  initial begin
    logic [63:0] directed_keys [14];
    directed_keys = '{
      64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
      64'h1334_5779_9BBC_DFF1, 64'h0123_4567_89AB_CDEF,
      64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
      // weak keys: all subkeys equal
      64'h0101_0101_0101_0101, 64'hFEFE_FEFE_FEFE_FEFE,
      64'h1F1F_1F1F_0E0E_0E0E, 64'hE0E0_E0E0_F1F1_F1F1,
      // semi-weak key, and parity bits alone (must give all-zero subkeys)
      64'h01FE_01FE_01FE_01FE, 64'h0101_0101_0101_0100 | 64'h0001_0000_0000_0001,
      // extreme single bits
      64'h8000_0000_0000_0000, 64'h0000_0000_0000_0002
    };
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    hold_toggle = 1'b0;
    tx_idle_pct = 14;
    rx_idle_pct = 75;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // phase one: slow receiver
    foreach (directed_keys[i]) send_key(directed_keys[i]);
    repeat (40) send_key(pick_key());
    drain();

    // phase two: slow sender, starting with a long receiver hold-off so the
    // block fills and backs up its input while keys keep being offered
    tx_idle_pct = 75;
    rx_idle_pct = 14;
    hold_toggle = ~hold_toggle;
    tx_idle_pct = 0;
    repeat (10) send_key(pick_key());
    tx_idle_pct = 75;
    repeat (50) send_key(pick_key());
    drain();

    // phase three: no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (55) send_key(pick_key());
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/dks_pkg.sv
src/dks_pc1.sv
src/dks_rounds.sv
src/dks_pc2.sv
src/des_key_schedule.sv
src/dks_checker.sv
dv/dks_subkey_checker.sv
dv/des_key_schedule_tb.sv
